@@ hdl/sdinit_pkg.sv @@
// Package: shared types and constants for the SD card init sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sdinit_pkg;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_W0    = 4'd1,
    PH_W8    = 4'd2,
    PH_W55   = 4'd3,
    PH_W41   = 4'd4,
    PH_W2    = 4'd5,
    PH_W3    = 4'd6,
    PH_W7    = 4'd7,
    PH_READY = 4'd8
  } phase_t;

  // Event kinds
  localparam logic OP_DETECT   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // Command completion status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_STUCK   = 2'd3;

  // Expected response kinds
  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_SHORT = 2'd1;
  localparam logic [1:0] RK_LONG  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_CMD55       = 3'd1;
  localparam logic [2:0] ERR_NO_CARD     = 3'd2;
  localparam logic [2:0] ERR_NEVER_READY = 3'd3;
  localparam logic [2:0] ERR_CMD2        = 3'd4;
  localparam logic [2:0] ERR_CMD3        = 3'd5;
  localparam logic [2:0] ERR_CMD7        = 3'd6;

  // SD command numbers
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_SEND_OP   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;

  localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
  localparam logic [11:0] ECHO_VALUE  = 12'h1AA;

  // Configuration register indexes and reset values
  localparam logic CFG_RETRY_LIMIT    = 1'b0;
  localparam logic CFG_VOLTAGE_WINDOW = 1'b1;

  localparam logic [15:0] RETRY_LIMIT_RST    = 16'd1000;
  localparam logic [23:0] VOLTAGE_WINDOW_RST = 24'h10_0000;

  typedef struct packed {
    logic        opcode;
    logic        card_in;
    logic [1:0]  cmd_status;
    logic [31:0] resp_word;
  } sd_evt_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic        card_ready;
    logic [2:0]  error_code;
    logic [15:0] card_address;
    logic        high_capacity;
  } sd_res_t;

  typedef struct packed {
    logic [15:0] retry_limit;
    logic [23:0] voltage_window;
  } sd_cfg_t;

endpackage

`default_nettype wire

@@ hdl/sdinit_cfg.sv @@
// Configuration registers: CMD41 retry limit and voltage window.
`timescale 1ns / 1ps
`default_nettype none

module sdinit_cfg
  import sdinit_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data,
  output sd_cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit    <= RETRY_LIMIT_RST;
      cfg.voltage_window <= VOLTAGE_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT:    cfg.retry_limit    <= cfg_data[15:0];
        CFG_VOLTAGE_WINDOW: cfg.voltage_window <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/sdinit_core.sv @@
// Bring-up state machine: state registers and the per-item next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module sdinit_core
  import sdinit_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  sd_evt_t   evt,
  input  sd_cfg_t   cfg,
  output sd_res_t   res
);

  phase_t      phase, phase_next;
  logic        ready_flag, ready_flag_next;
  logic        cap_flag, cap_flag_next;
  logic [15:0] rca, rca_next;
  logic [15:0] tries_left, tries_left_next;
  // only bit 31 of the last captured response is ever tested
  logic        busy_done, busy_done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      ready_flag <= 1'b0;
      cap_flag   <= 1'b0;
      rca        <= '0;
      tries_left <= '0;
      busy_done  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      ready_flag <= ready_flag_next;
      cap_flag   <= cap_flag_next;
      rca        <= rca_next;
      tries_left <= tries_left_next;
      busy_done  <= busy_done_next;
    end
  end

  always_comb begin
    logic        st_bad;
    logic [15:0] tries_dec;
    st_bad    = (evt.cmd_status == ST_TIMEOUT) || (evt.cmd_status == ST_STUCK);
    tries_dec = tries_left - 16'd1;

    phase_next      = phase;
    ready_flag_next = ready_flag;
    cap_flag_next   = cap_flag;
    rca_next        = rca;
    tries_left_next = tries_left;
    busy_done_next  = busy_done;

    res = '0;

    if (evt.opcode == OP_DETECT) begin
      if (phase == PH_READY && !evt.card_in) begin
        ready_flag_next = 1'b0;
        cap_flag_next   = 1'b0;
        rca_next        = '0;
        phase_next      = PH_IDLE;
      end else if (phase == PH_IDLE && evt.card_in) begin
        cap_flag_next = 1'b0;
        res.cmd_valid = 1'b1;
        res.cmd_index = CMD_GO_IDLE;
        res.resp_kind = RK_NONE;
        phase_next    = PH_W0;
      end
    end else begin
      // capture bit 31 of the response word of commands that return one, unless timed out or stuck
      if (phase >= PH_W8 && phase <= PH_W7 && !st_bad)
        busy_done_next = evt.resp_word[31];

      unique case (phase)
        PH_W0: begin
          res.cmd_valid = 1'b1;
          res.cmd_index = CMD_IF_COND;
          res.cmd_arg   = IF_COND_ARG;
          res.resp_kind = RK_SHORT;
          phase_next    = PH_W8;
        end
        PH_W8: begin
          if (evt.cmd_status == ST_OK && evt.resp_word[11:0] == ECHO_VALUE)
            cap_flag_next = 1'b1;
          tries_left_next = (cfg.retry_limit == '0) ? 16'd1 : cfg.retry_limit;
          res.cmd_valid = 1'b1;
          res.cmd_index = CMD_APP;
          res.resp_kind = RK_SHORT;
          phase_next    = PH_W55;
        end
        PH_W55: begin
          if (st_bad) begin
            res.error_code = ERR_CMD55;
            phase_next     = PH_IDLE;
          end else begin
            res.cmd_valid = 1'b1;
            res.cmd_index = CMD_SEND_OP;
            res.cmd_arg   = {1'b0, cap_flag, 6'b0, cfg.voltage_window};
            res.resp_kind = RK_SHORT;
            phase_next    = PH_W41;
          end
        end
        PH_W41: begin
          if (evt.cmd_status == ST_TIMEOUT) begin
            res.error_code = ERR_NO_CARD;
            phase_next     = PH_IDLE;
          end else if (busy_done_next) begin
            res.cmd_valid = 1'b1;
            res.cmd_index = CMD_ALL_CID;
            res.resp_kind = RK_LONG;
            phase_next    = PH_W2;
          end else begin
            tries_left_next = tries_dec;
            if (tries_dec == '0) begin
              res.error_code = ERR_NEVER_READY;
              phase_next     = PH_IDLE;
            end else begin
              res.cmd_valid = 1'b1;
              res.cmd_index = CMD_APP;
              res.resp_kind = RK_SHORT;
              phase_next    = PH_W55;
            end
          end
        end
        PH_W2: begin
          if (st_bad) begin
            res.error_code = ERR_CMD2;
            phase_next     = PH_IDLE;
          end else begin
            res.cmd_valid = 1'b1;
            res.cmd_index = CMD_SEND_RCA;
            res.resp_kind = RK_SHORT;
            phase_next    = PH_W3;
          end
        end
        PH_W3: begin
          if (evt.cmd_status != ST_OK) begin
            res.error_code = ERR_CMD3;
            phase_next     = PH_IDLE;
          end else begin
            rca_next      = evt.resp_word[31:16];
            res.cmd_valid = 1'b1;
            res.cmd_index = CMD_SELECT;
            res.cmd_arg   = {evt.resp_word[31:16], 16'h0000};
            res.resp_kind = RK_SHORT;
            phase_next    = PH_W7;
          end
        end
        PH_W7: begin
          if (evt.cmd_status != ST_OK) begin
            res.error_code = ERR_CMD7;
            phase_next     = PH_IDLE;
          end else begin
            ready_flag_next = 1'b1;
            phase_next      = PH_READY;
          end
        end
        default: ; // idle or ready: drop the completion
      endcase
    end

    res.card_ready    = ready_flag_next;
    res.card_address  = rca_next;
    res.high_capacity = cap_flag_next;
  end

endmodule

`default_nettype wire

@@ hdl/sd_card_init_sequencer_top.sv @@
// Top level: event input register, sequencer core and result register.
//
// SD card bring-up sequencer. Each item on evt is a card-detect sample or the
// completion of the last issued command; each produces exactly one item on res
// carrying the command to issue next (if any), an error code and the current
// ready/address/capacity status. Items pass through an input register and a
// result register with the state machine between them, so the result of an
// item is valid on res once it has passed both registers, and one item is
// accepted every cycle as long as res is taken. Configuration writes (retry
// limit, voltage window) take effect at once and should be made only while no
// item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module sd_card_init_sequencer_top
  import sdinit_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        evt_valid,
  output logic             evt_ready,
  input  sd_evt_t          evt,
  output logic             res_valid,
  input  wire logic        res_ready,
  output sd_res_t          res
);

  sd_cfg_t cfg;
  sd_evt_t stg;
  logic    stg_valid;
  logic    step;
  sd_res_t core_res;

  sdinit_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the staged item when the result register is free or being drained
  assign step      = stg_valid && (!res_valid || res_ready);
  assign evt_ready = !stg_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (evt_ready) begin
      stg_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      stg <= evt;
    end
  end

  sdinit_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .evt  (stg),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= core_res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sdinit_checker.sv @@
// Port-level checker for the SD card init sequencer, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module sdinit_checker
  import sdinit_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input sd_res_t          res
);

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // no command means empty command fields
  a_idle_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.cmd_valid |->
      res.cmd_index == '0 && res.cmd_arg == '0 && res.resp_kind == RK_NONE)
    else $error("command fields set without a command");

  // a failing item issues nothing and leaves the card not ready
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_code != ERR_NONE |-> !res.cmd_valid && !res.card_ready)
    else $error("error item with command or ready");

  // a ready card needs no further commands
  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.card_ready |-> !res.cmd_valid)
    else $error("command issued while ready");

  // nothing comes out the cycle after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind sd_card_init_sequencer_top sdinit_checker u_sdinit_checker (.*);

`default_nettype wire
